// ===== rtl/huffman_tree_decoder_assert.svh =====
// Assertion macros for the Huffman tree decoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HUFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("huffman_tree_decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define HUFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("huffman_tree_decoder: next-cycle check failed");

`endif

// ===== rtl/hufd_pkg.sv =====
// Shared types and constants of the Huffman tree decoder.
// No dependencies; every module and interface of the block imports this package.
`timescale 1ns / 1ps

package hufd_pkg;

    localparam int MAX_NODES   = 512;
    localparam int SYMBOL_BITS = 8;
    localparam int ADDR_W      = $clog2(MAX_NODES);
    localparam int IDX_W       = 9;
    localparam int SYM_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int TOP_BIT     = 7;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic                   leaf;
        logic [IDX_W-1:0]       left;
        logic [IDX_W-1:0]       right;
        logic [SYMBOL_BITS-1:0] symbol;
    } t_node;

    // controller -> datapath
    typedef struct packed {
        logic load;   // write one node, return walk to root
        logic start;  // latch byte, read the starting node
        logic cur;    // follow a child of a freshly read node
        logic step;   // finish one bit against the node just read
        logic flush;  // hand over the held symbol marked last
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic leaf;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } t_stat;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(MAX_NODES);
    endfunction

endpackage

// ===== rtl/hufd_in_if.sv =====
// Input channel of the Huffman tree decoder: valid/ready plus one item.
// Depends on hufd_pkg.
`timescale 1ns / 1ps

interface hufd_in_if import hufd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [IDX_W-1:0] node_left;
    logic [IDX_W-1:0] node_right;
    logic [SYM_W-1:0] node_symbol;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, kind, node_index, node_is_leaf, node_left, node_right,
                    node_symbol, data_byte, input ready);
    modport sink (input valid, kind, node_index, node_is_leaf, node_left, node_right,
                  node_symbol, data_byte, output ready);
endinterface

// ===== rtl/hufd_out_if.sv =====
// Output channel of the Huffman tree decoder: valid/ready plus one symbol.
// Depends on hufd_pkg.
`timescale 1ns / 1ps

interface hufd_out_if import hufd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, symbol, last, input ready);
    modport sink (input valid, symbol, last, output ready);
endinterface

// ===== rtl/hufd_ctrl.sv =====
// Control state machine of the Huffman tree decoder.
// Depends on hufd_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps

module hufd_ctrl import hufd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_kind,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CUR   = 4'b0010,
        S_STEP  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_step_go;
    logic   w_flush_go;

    // a found leaf with a symbol already held needs room in the output register
    assign w_step_go  = !i_stat.leaf || !i_stat.pend_valid || i_stat.out_free;
    assign w_flush_go = !i_stat.pend_valid || i_stat.out_free;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == KIND_DECODE) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_CUR;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_CUR: begin
                o_cmd.cur = 1'b1;
                n_state   = S_STEP;
            end
            S_STEP: begin
                if (w_step_go) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last_bit) begin
                        n_state = S_FLUSH;
                    end else if (i_stat.leaf) begin
                        n_state = S_CUR;
                    end
                end
            end
            S_FLUSH: begin
                if (w_flush_go) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/hufd_dpath.sv =====
// Datapath of the Huffman tree decoder: node memory, walk registers,
// held symbol and output register. Depends on hufd_pkg.
`timescale 1ns / 1ps

module hufd_dpath import hufd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_wr_en,
    input  logic [IDX_W-1:0]  i_cfg_wr_data,
    input  logic [IDX_W-1:0]  i_node_index,
    input  logic              i_node_is_leaf,
    input  logic [IDX_W-1:0]  i_node_left,
    input  logic [IDX_W-1:0]  i_node_right,
    input  logic [SYM_W-1:0]  i_node_symbol,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [SYM_W-1:0]  o_symbol,
    output logic              o_last
);

    t_node mem [MAX_NODES];

    logic [IDX_W-1:0]       r_root;
    logic [IDX_W-1:0]       r_walk_pos;
    logic                   r_walk_act;
    logic [BYTE_W-1:0]      r_bits;
    logic [BIT_CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]       r_next;
    t_node                  r_rd_data;
    logic                   r_rd_oob;
    logic                   r_pend_valid;
    logic [SYMBOL_BITS-1:0] r_pend_sym;
    logic                   r_out_valid;
    logic [SYM_W-1:0]       r_out_symbol;
    logic                   r_out_last;

    t_node            w_node;
    logic             w_last_bit;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_push;

    // nodes beyond the store read as an all-zero inner node
    assign w_node     = r_rd_oob ? t_node'('0) : r_rd_data;
    assign w_last_bit = (r_cnt == BIT_CNT_W'(TOP_BIT));

    always_comb begin
        w_rd_en  = 1'b0;
        w_rd_idx = r_root;
        if (i_cmd.start) begin
            w_rd_en  = 1'b1;
            w_rd_idx = r_walk_act ? r_walk_pos : r_root;
        end else if (i_cmd.cur) begin
            w_rd_en  = 1'b1;
            w_rd_idx = r_bits[TOP_BIT] ? w_node.right : w_node.left;
        end else if (i_cmd.step && !w_last_bit) begin
            // after a leaf restart at the root, else chain to the next child
            w_rd_en = 1'b1;
            if (w_node.leaf) begin
                w_rd_idx = r_root;
            end else begin
                w_rd_idx = r_bits[TOP_BIT-1] ? w_node.right : w_node.left;
            end
        end
    end

    assign w_push = (i_cmd.step && w_node.leaf && r_pend_valid)
                  || (i_cmd.flush && r_pend_valid);

    // node memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range(i_node_index)) begin
            mem[to_addr(i_node_index)] <= '{leaf:   i_node_is_leaf,
                                            left:   i_node_left,
                                            right:  i_node_right,
                                            symbol: SYMBOL_BITS'(i_node_symbol)};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[to_addr(w_rd_idx)];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_next   <= w_rd_idx;
            r_rd_oob <= !in_range(w_rd_idx);
        end
        if (i_cmd.start) begin
            r_bits <= i_data_byte;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_bits <= {r_bits[BYTE_W-2:0], 1'b0};
            r_cnt  <= r_cnt + BIT_CNT_W'(1);
        end
        if (i_cmd.step && w_node.leaf) begin
            r_pend_sym <= w_node.symbol;
        end
        if (w_push) begin
            r_out_symbol <= SYM_W'(r_pend_sym);
            r_out_last   <= i_cmd.flush;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_walk_pos   <= '0;
            r_walk_act   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_walk_act <= 1'b0;
            end else if (i_cmd.step) begin
                if (w_node.leaf) begin
                    r_walk_act <= 1'b0;
                end else begin
                    r_walk_act <= 1'b1;
                    r_walk_pos <= r_next;
                end
            end
            if (i_cmd.step && w_node.leaf) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.leaf       = w_node.leaf;
    assign o_stat.last_bit   = w_last_bit;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_symbol;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/huffman_tree_decoder.sv =====
// Huffman tree decoder: node memory walked bit by bit for each input byte.
// Top level; depends on hufd_pkg, hufd_in_if, hufd_out_if, hufd_ctrl, hufd_dpath
// and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_decoder_assert.svh"

// The block holds a code tree of up to 512 nodes in a single-port-read memory.
// A load item (kind 0) writes one node and returns the walk to the root; it is
// accepted while staying idle and yields no symbol. A decode item (kind 1) brings one
// byte whose bits are walked most significant first, 1 to the right child and
// 0 to the left; each leaf reached emits its symbol and restarts at the root.
// The walk position carries over between bytes, so codes may span bytes. The
// last symbol of a byte is flagged with last; a byte may yield no symbol at all.
// Each decoded byte is paced by the chain of dependent node reads through the
// memory's one registered read port: one read per bit and one extra read to
// fetch the root after each leaf reached before its final bit. The next item is
// taken only once the byte is flushed. A stalled output holds the walk when a
// symbol is still held and a further one is found or the byte is flushed.
// Symbols are held one deep so that last can be attached; the output register
// lets the next item in while a symbol waits.
// The user must write the root register (i_cfg_wr_en / i_cfg_wr_data) only while idle; the block does not enforce it.
// Node memory contents are undefined after reset; write every node before use.

module huffman_tree_decoder import hufd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_wr_data,
    hufd_in_if.sink          i_in,
    hufd_out_if.source       o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // sequencer: idle, follow child, finish bit, flush the held symbol
    hufd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // memory, walk position, held symbol and output register
    hufd_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_node_index   (i_in.node_index),
        .i_node_is_leaf (i_in.node_is_leaf),
        .i_node_left    (i_in.node_left),
        .i_node_right   (i_in.node_right),
        .i_node_symbol  (i_in.node_symbol),
        .i_data_byte    (i_in.data_byte),
        .i_out_ready    (o_out.ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .o_symbol       (o_out.symbol),
        .o_last         (o_out.last)
    );

    assign i_in.ready = w_in_ready;

    // a flush always empties the held symbol
    `HUFD_ASSERT_NEXT(a_flush_empties, w_cmd.flush, !w_stat.pend_valid)
    // on a step at a leaf, a held symbol is only pushed out when the output register has room
    `HUFD_ASSERT_NOW(a_push_has_room, w_cmd.step && w_stat.leaf && w_stat.pend_valid,
                     w_stat.out_free)
    // while taking items no symbol of an earlier byte may still be held
    `HUFD_ASSERT_NOW(a_idle_no_pend, w_in_ready, !w_stat.pend_valid)
    // a started byte first follows a child of the starting node
    `HUFD_ASSERT_NEXT(a_start_then_cur, w_cmd.start, w_cmd.cur)

endmodule
